### rtl/frma_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package frma_pkg;

    localparam int WINDOW        = 60;
    localparam int TICKS_W       = 24;
    localparam int HZ_W          = 32;
    localparam int FPS_W         = 24;
    localparam int ELAPSED_W     = 48;
    localparam int FRAC_W        = 8;

    localparam int RESET_TICKS   = 16667;
    localparam int TICK_HZ_RESET = 1000000;

    localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int WIN_W = $clog2(WINDOW + 1);

    localparam longint SUM_MAX = longint'(WINDOW) * ((longint'(1) << TICKS_W) - 1);
    localparam int     SUM_W   = $clog2(SUM_MAX + 1);
    localparam longint SUM_RST = longint'(WINDOW) * longint'(RESET_TICKS);

    localparam int NUM_W = HZ_W + WIN_W + FRAC_W;
    localparam int CNT_W = $clog2(NUM_W + 1);

    // floor(sum / WINDOW) as (sum * RECIP_MULT) >> RECIP_SHIFT, exact for sum < 2^SUM_W
    localparam int     RECIP_SHIFT = SUM_W + WIN_W;
    localparam longint RECIP_MULT  =
        ((longint'(1) << RECIP_SHIFT) + longint'(WINDOW) - 1) / longint'(WINDOW);
    localparam int     RECIP_W     = $clog2(RECIP_MULT + 1);
    localparam int     PROD_W      = SUM_W + RECIP_W;

    typedef struct packed {
        logic start;
    } frma_div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } frma_div_stat_t;

endpackage

`default_nettype wire

### rtl/frma_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module frma_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                          clk,
    input  wire logic                                          we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                              wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output      logic [WIDTH-1:0]                              rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

### rtl/frma_div.sv
`timescale 1ns / 1ps
`default_nettype none

// restoring divider, one quotient bit per cycle
module frma_div
    import frma_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire frma_div_req_t        req,
    input  wire logic [NUM_W-1:0]     num,
    input  wire logic [SUM_W-1:0]     den,
    output      frma_div_stat_t       stat,
    output      logic [NUM_W-1:0]     quot
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [SUM_W-1:0] rem_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [SUM_W-1:0] den_reg;

    logic [SUM_W:0]   shifted;
    logic [SUM_W+1:0] diff;
    logic             q_bit;
    logic [SUM_W-1:0] rem_step;

    always_comb
    begin
        shifted  = {rem_reg, quo_reg[NUM_W-1]};
        diff     = {1'b0, shifted} - {2'b00, den_reg};
        q_bit    = ~diff[SUM_W+1];
        rem_step = q_bit ? diff[SUM_W-1:0] : shifted[SUM_W-1:0];
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_step;
            quo_reg <= {quo_reg[NUM_W-2:0], q_bit};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = quo_reg;

endmodule

`default_nettype wire

### rtl/frame_rate_moving_average_unit.sv
// Frame-rate meter over a sliding window of the last 60 frame times. Each input word is one
// frame time in reference-clock ticks; one result word follows with the smoothed rate
// (60 * tick_hz / window sum, unsigned 16.8, truncated, saturating, 0 for a zero sum), the mean
// frame time and a 48-bit wrapping elapsed count. After acceptance a word goes through these
// steps in order: the ring and sum are updated, the divider is started and the mean is formed,
// the bit-serial rate divider runs (one quotient bit per cycle), the divider raises its done
// flag, and the output register is loaded once it is free. in_stall is high throughout,
// and for as long as a stalled result holds off the load, so a word is taken only once the
// previous result has been loaded; a finished result may wait in the output register while
// the next word is accepted. After reset the ring reads as 16667 ticks per entry, whatever
// tick_hz is; no clearing pass is needed. tick_hz is written through the cfg channel, always
// ready, and is sampled when a word is accepted.
`timescale 1ns / 1ps
`default_nettype none

module frame_rate_moving_average_unit
    import frma_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output      logic                   in_stall,
    input  wire logic [TICKS_W-1:0]     frame_ticks,
    output      logic                   out_valid,
    input  wire logic                   out_stall,
    output      logic [FPS_W-1:0]       fps_fixed,
    output      logic [TICKS_W-1:0]     avg_frame_ticks,
    output      logic [ELAPSED_W-1:0]   elapsed_ticks,
    input  wire logic                   cfg_valid,
    output      logic                   cfg_ready,
    input  wire logic [HZ_W-1:0]        cfg_data
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_READ = 5'b00010,
        ST_MUL  = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    state_t                 state_reg, state_next;
    logic [HZ_W-1:0]        tick_hz_reg;
    logic [WINDOW-1:0]      valid_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [ELAPSED_W-1:0]   elapsed_reg;
    logic                   out_valid_reg, out_valid_next;

    logic [TICKS_W-1:0]     ticks_reg;
    logic [NUM_W-1:0]       num_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [FPS_W-1:0]       fps_reg;
    logic [TICKS_W-1:0]     avg_reg;
    logic [ELAPSED_W-1:0]   elapsed_out_reg;

    logic                   in_take;
    logic                   out_take;
    logic                   out_load;
    logic [TICKS_W-1:0]     ram_rdata;
    logic [TICKS_W-1:0]     old_ticks;
    logic [SUM_W-1:0]       sum_upd;
    logic [FPS_W-1:0]       fps_val;
    frma_div_req_t          div_req;
    frma_div_stat_t         div_stat;
    logic [NUM_W-1:0]       div_quot;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    assign old_ticks = valid_reg[idx_reg] ? ram_rdata : TICKS_W'(RESET_TICKS);
    assign sum_upd   = sum_reg - SUM_W'(old_ticks) + SUM_W'(ticks_reg);

    assign div_req.start = (state_reg == ST_MUL);

    always_comb
    begin
        if (sum_reg == '0)
        begin
            fps_val = '0;
        end
        else if (|div_quot[NUM_W-1:FPS_W])
        begin
            fps_val = '1;
        end
        else
        begin
            fps_val = div_quot[FPS_W-1:0];
        end
    end

    frma_ram #(
        .WIDTH (TICKS_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (state_reg == ST_READ),
        .waddr (idx_reg),
        .wdata (ticks_reg),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    frma_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .num   (num_reg),
        .den   (sum_reg),
        .stat  (div_stat),
        .quot  (div_quot)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ: state_next = ST_MUL;
            ST_MUL:  state_next = ST_DIV;
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tick_hz_reg   <= HZ_W'(TICK_HZ_RESET);
            valid_reg     <= '0;
            idx_reg       <= '0;
            sum_reg       <= SUM_W'(SUM_RST);
            elapsed_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                tick_hz_reg <= cfg_data;
            end
            if (state_reg == ST_READ)
            begin
                valid_reg[idx_reg] <= 1'b1;
                sum_reg            <= sum_upd;
                elapsed_reg        <= elapsed_reg + ELAPSED_W'(ticks_reg);
                if (idx_reg == IDX_W'(WINDOW - 1))
                begin
                    idx_reg <= '0;
                end
                else
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            ticks_reg <= frame_ticks;
            num_reg   <= {(HZ_W + WIN_W)'(tick_hz_reg) * (HZ_W + WIN_W)'(WINDOW),
                          {FRAC_W{1'b0}}};
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= PROD_W'(sum_reg) * PROD_W'(RECIP_MULT);
        end
        if (out_load)
        begin
            fps_reg         <= fps_val;
            avg_reg         <= prod_reg[RECIP_SHIFT +: TICKS_W];
            elapsed_out_reg <= elapsed_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign fps_fixed       = fps_reg;
    assign avg_frame_ticks = avg_reg;
    assign elapsed_ticks   = elapsed_out_reg;

endmodule

`default_nettype wire

### rtl/frma_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module frma_checker
    import frma_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    input  wire logic                   in_stall,
    input  wire logic [TICKS_W-1:0]     frame_ticks,
    input  wire logic                   out_valid,
    input  wire logic                   out_stall,
    input  wire logic [FPS_W-1:0]       fps_fixed,
    input  wire logic [TICKS_W-1:0]     avg_frame_ticks,
    input  wire logic [ELAPSED_W-1:0]   elapsed_ticks,
    input  wire logic                   cfg_valid,
    input  wire logic                   cfg_ready,
    input  wire logic [HZ_W-1:0]        cfg_data
);

    logic in_word;
    logic out_word;

    assign in_word  = in_valid && !in_stall;
    assign out_word = out_valid && !out_stall;

    // busy for at least the ring read and update after a word is taken
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_word |=> in_stall ##1 in_stall)
        else $error("block ready again too soon after taking a word");

    // no result rises during the ring update and divider start that follow a taken word
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_word |=> !$rose(out_valid) ##1 !$rose(out_valid))
        else $error("result appeared before the divide could finish");

    // a result replaced in the same cycle it is taken leaves the block idle
    a_reload_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_word |=> !out_valid || !in_stall)
        else $error("output reloaded without the block returning to idle");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid && $stable(fps_fixed)
            && $stable(avg_frame_ticks) && $stable(elapsed_ticks))
        else $error("stalled result word changed");

endmodule

bind frame_rate_moving_average_unit frma_checker u_frma_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .frame_ticks     (frame_ticks),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .fps_fixed       (fps_fixed),
    .avg_frame_ticks (avg_frame_ticks),
    .elapsed_ticks   (elapsed_ticks),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
);

`default_nettype wire
